// ----- rtl/abkf_pkg.sv -----
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and constants of the angle and bias Kalman filter
// Holds the micro-operation format, the operand codes and the fixed program
// that the sequencer steps through for one sample.
// ----------------------------------------------------------------------------
package abkf_pkg;

  // Pi and two pi with 24 fraction bits, rounded to the working format later.
  localparam longint PI_Q24     = 64'sd52707179;
  localparam longint TWO_PI_Q24 = 64'sd105414357;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEP_TIME  = 3'd0;
  localparam logic [2:0] REG_ANGLE_NOISE = 3'd1;
  localparam logic [2:0] REG_RATE_PROC  = 3'd2;
  localparam logic [2:0] REG_BIAS_PROC  = 3'd3;
  localparam logic [2:0] REG_CROSS_PROC = 3'd4;

  // Operations of the shared unit.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Operand and destination codes.
  localparam logic [3:0] SEL_P11  = 4'd0;
  localparam logic [3:0] SEL_P12  = 4'd1;
  localparam logic [3:0] SEL_P22  = 4'd2;
  localparam logic [3:0] SEL_ANG  = 4'd3;
  localparam logic [3:0] SEL_BIAS = 4'd4;
  localparam logic [3:0] SEL_Z    = 4'd5;
  localparam logic [3:0] SEL_RATE = 4'd6;
  localparam logic [3:0] SEL_T    = 4'd7;
  localparam logic [3:0] SEL_YS   = 4'd8;
  localparam logic [3:0] SEL_S    = 4'd9;
  localparam logic [3:0] SEL_DT   = 4'd10;
  localparam logic [3:0] SEL_RV   = 4'd11;
  localparam logic [3:0] SEL_QR   = 4'd12;
  localparam logic [3:0] SEL_QB   = 4'd13;
  localparam logic [3:0] SEL_QC   = 4'd14;

  localparam logic [4:0] PC_LAST = 5'd30;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
  } uop_t;

  // The filter update as a list of two-operand steps on the shared unit.
  function automatic uop_t uop_at(logic [4:0] pc);
    uop_t u;
    u = '{OP_ADD, SEL_T, SEL_T, SEL_T};
    case (pc)
      5'd0:  u = '{OP_SUB, SEL_T,    SEL_RATE, SEL_BIAS};
      5'd1:  u = '{OP_MUL, SEL_T,    SEL_T,    SEL_DT};
      5'd2:  u = '{OP_ADD, SEL_ANG,  SEL_ANG,  SEL_T};
      5'd3:  u = '{OP_MUL, SEL_T,    SEL_P12,  SEL_DT};
      5'd4:  u = '{OP_SUB, SEL_P11,  SEL_P11,  SEL_T};
      5'd5:  u = '{OP_MUL, SEL_T,    SEL_P22,  SEL_DT};
      5'd6:  u = '{OP_SUB, SEL_P12,  SEL_P12,  SEL_T};
      5'd7:  u = '{OP_MUL, SEL_T,    SEL_P12,  SEL_DT};
      5'd8:  u = '{OP_SUB, SEL_P11,  SEL_P11,  SEL_T};
      5'd9:  u = '{OP_MUL, SEL_T,    SEL_QR,   SEL_DT};
      5'd10: u = '{OP_MUL, SEL_T,    SEL_T,    SEL_DT};
      5'd11: u = '{OP_ADD, SEL_P11,  SEL_P11,  SEL_T};
      5'd12: u = '{OP_MUL, SEL_T,    SEL_QC,   SEL_DT};
      5'd13: u = '{OP_ADD, SEL_P12,  SEL_P12,  SEL_T};
      5'd14: u = '{OP_ADD, SEL_P22,  SEL_P22,  SEL_QB};
      5'd15: u = '{OP_ADD, SEL_S,    SEL_P11,  SEL_RV};
      5'd16: u = '{OP_SUB, SEL_T,    SEL_Z,    SEL_ANG};
      5'd17: u = '{OP_DIV, SEL_YS,   SEL_T,    SEL_S};
      5'd18: u = '{OP_MUL, SEL_T,    SEL_P11,  SEL_YS};
      5'd19: u = '{OP_ADD, SEL_ANG,  SEL_ANG,  SEL_T};
      5'd20: u = '{OP_MUL, SEL_T,    SEL_P12,  SEL_YS};
      5'd21: u = '{OP_ADD, SEL_BIAS, SEL_BIAS, SEL_T};
      5'd22: u = '{OP_MUL, SEL_T,    SEL_P12,  SEL_P12};
      5'd23: u = '{OP_DIV, SEL_T,    SEL_T,    SEL_S};
      5'd24: u = '{OP_SUB, SEL_P22,  SEL_P22,  SEL_T};
      5'd25: u = '{OP_MUL, SEL_T,    SEL_P12,  SEL_P11};
      5'd26: u = '{OP_DIV, SEL_T,    SEL_T,    SEL_S};
      5'd27: u = '{OP_SUB, SEL_P12,  SEL_P12,  SEL_T};
      5'd28: u = '{OP_MUL, SEL_T,    SEL_P11,  SEL_P11};
      5'd29: u = '{OP_DIV, SEL_T,    SEL_T,    SEL_S};
      5'd30: u = '{OP_SUB, SEL_P11,  SEL_P11,  SEL_T};
      default: u = '{OP_ADD, SEL_T, SEL_T, SEL_T};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/angle_bias_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: one-axis angle and gyro bias Kalman filter
// Unwraps a wrapped angle measurement, predicts with the bias-corrected
// gyro rate and applies the gain update, all in saturating fixed point.
// ----------------------------------------------------------------------------
// One request carries a wrapped angle and a gyro rate and yields one result
// with the unwrapped filtered angle, the corrected rate and the bias. A small
// sequencer runs a fixed program of 31 steps on one shared arithmetic unit:
// an add or subtract writes back straight from the issue state, a multiply
// works through four multiplier bits per cycle and a divide produces
// WORD_WIDTH+FRACTION_BITS quotient bits, one quotient bit per cycle, or
// writes zero without running the divider when the divisor is zero. The
// program holds four divisions and twelve multiplies. Each request passes
// through unwrapping and the program and then loads the output register,
// which holds the result until the consumer takes it. The block takes the
// next request once the result has been handed to the output register, and
// waits while that register still holds a result the consumer has not taken.
// Configuration registers are to be written by the user through the plain
// write port only while the block is idle; the block itself does not enforce
// this. Indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter
  import abkf_pkg::*;
#(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [18:0] angle_in_i,
  input  logic signed [31:0] rate_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] corrected_rate_o,
  output logic signed [31:0] bias_estimate_o
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRACTION_BITS;
  localparam int XW    = 2 * W + 8;
  localparam int NSTEP = (W + 3) / 4;
  localparam int BW    = 4 * NSTEP;
  localparam int DW    = W + F;
  localparam int CW    = $clog2(DW + 1);

  localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
  localparam logic signed [XW-1:0] O32MAX = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] O32MIN = ~O32MAX;
  localparam logic signed [XW-1:0] PI_X =
    XW'((((PI_Q24 * 2) >>> (24 - F)) + 1) >>> 1);
  localparam logic signed [XW-1:0] TWO_PI_X =
    XW'((((TWO_PI_Q24 * 2) >>> (24 - F)) + 1) >>> 1);
  localparam logic [XW-1:0] RND_X = XW'(1) << (F - 1);
  localparam logic [CW-1:0] MUL_END = CW'(NSTEP);
  localparam logic [CW-1:0] DIV_END = CW'(DW);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UNWRAP = 3'd1;
  localparam logic [2:0] ST_ZADJ   = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  function automatic logic signed [W-1:0] sat_x(logic signed [XW-1:0] v);
    if (v > WMAX_X) return WMAX;
    if (v < WMIN_X) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sum(logic signed [W:0] v);
    if (v[W] != v[W-1]) return v[W] ? WMIN : WMAX;
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // Clamp a magnitude to the word and give it its sign.
  function automatic logic signed [W-1:0] apply_sign(logic [XW-1:0] m, logic neg);
    logic [XW-1:0] lim;
    lim = XW'(WMAX_X) + XW'(neg);
    if (m > lim) m = lim;
    return neg ? W'(-m[W-1:0]) : m[W-1:0];
  endfunction

  function automatic logic [31:0] out32(logic signed [W-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v);
    if (x > O32MAX) return O32MAX[31:0];
    if (x < O32MIN) return O32MIN[31:0];
    return x[31:0];
  endfunction

  // Configuration registers.
  logic [16:0] step_time_q;
  logic [30:0] angle_noise_q, rate_proc_q, bias_proc_q, cross_proc_q;

  // Filter state.
  logic signed [W-1:0] ang_q, bias_q, p11_q, p12_q, p22_q, prev_q;
  logic [15:0]         turn_q;

  // Working registers of one request.
  logic signed [W-1:0] z_q, rate_q, t_q, ys_q, s_q;

  // Sequencer and shared unit.
  logic [2:0]    state_q, state_d;
  logic [4:0]    pc_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [W-1:0]  ma_q;
  logic [BW-1:0] mb_q;
  logic [2*W-1:0] acc_q;
  logic [DW-1:0] dq_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  ud_q;
  logic          out_valid_q;
  logic [31:0]   ang_out_q, rate_out_q, bias_out_q;

  uop_t                u;
  logic signed [W-1:0] opa, opb;
  logic signed [W-1:0] dt_w, rv_w, qr_w, qb_w, qc_w;
  logic                in_acc;
  logic                wb_en;
  logic signed [W-1:0] wb_val;
  logic                out_load;
  logic signed [XW-1:0] z_x, prev_x;
  logic [2*W-1:0]      acc_d;
  logic [W:0]          r2;
  logic                ge;
  logic [XW-1:0]       mul_rnd;

  assign u      = uop_at(pc_q);
  assign dt_w   = sat_x(XW'(step_time_q));
  assign rv_w   = sat_x(XW'(angle_noise_q));
  assign qr_w   = sat_x(XW'(rate_proc_q));
  assign qb_w   = sat_x(XW'(bias_proc_q));
  assign qc_w   = sat_x(XW'(cross_proc_q));
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign z_x    = XW'(z_q);
  assign prev_x = XW'(prev_q);

  always_comb begin
    case (u.a)
      SEL_P11:  opa = p11_q;
      SEL_P12:  opa = p12_q;
      SEL_P22:  opa = p22_q;
      SEL_ANG:  opa = ang_q;
      SEL_BIAS: opa = bias_q;
      SEL_Z:    opa = z_q;
      SEL_RATE: opa = rate_q;
      SEL_T:    opa = t_q;
      SEL_YS:   opa = ys_q;
      SEL_S:    opa = s_q;
      SEL_DT:   opa = dt_w;
      SEL_RV:   opa = rv_w;
      SEL_QR:   opa = qr_w;
      SEL_QB:   opa = qb_w;
      SEL_QC:   opa = qc_w;
      default:  opa = '0;
    endcase
  end

  always_comb begin
    case (u.b)
      SEL_P11:  opb = p11_q;
      SEL_P12:  opb = p12_q;
      SEL_P22:  opb = p22_q;
      SEL_ANG:  opb = ang_q;
      SEL_BIAS: opb = bias_q;
      SEL_Z:    opb = z_q;
      SEL_RATE: opb = rate_q;
      SEL_T:    opb = t_q;
      SEL_YS:   opb = ys_q;
      SEL_S:    opb = s_q;
      SEL_DT:   opb = dt_w;
      SEL_RV:   opb = rv_w;
      SEL_QR:   opb = qr_w;
      SEL_QB:   opb = qb_w;
      SEL_QC:   opb = qc_w;
      default:  opb = '0;
    endcase
  end

  // One multiplier step takes four bits of the second operand, top first.
  assign acc_d   = (acc_q << 4) + (2*W)'(ma_q * mb_q[BW-1 -: 4]);
  // One restoring divider step.
  assign r2      = {rem_q, dq_q[DW-1]};
  assign ge      = r2 >= {1'b0, ud_q};
  assign mul_rnd = (XW'(acc_q) + RND_X) >> F;

  // Sequencer and write-back selection.
  always_comb begin
    state_d  = state_q;
    wb_en    = 1'b0;
    wb_val   = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_UNWRAP;
      end
      ST_UNWRAP: state_d = ST_ZADJ;
      ST_ZADJ:   state_d = ST_ISSUE;
      ST_ISSUE: begin
        case (u.op)
          OP_ADD: begin
            wb_en  = 1'b1;
            wb_val = sat_sum((W+1)'(opa) + (W+1)'(opb));
          end
          OP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sat_sum((W+1)'(opa) - (W+1)'(opb));
          end
          OP_MUL: state_d = ST_MUL;
          OP_DIV: begin
            if (opb == '0) begin
              wb_en  = 1'b1;
              wb_val = '0;
            end else begin
              state_d = ST_DIV;
            end
          end
          default: state_d = ST_ISSUE;
        endcase
      end
      ST_MUL: begin
        if (cnt_q == MUL_END) begin
          wb_en  = 1'b1;
          wb_val = apply_sign(mul_rnd, neg_q);
        end
      end
      ST_DIV: begin
        if (cnt_q == DIV_END) begin
          wb_en  = 1'b1;
          wb_val = apply_sign(XW'(dq_q), neg_q);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (wb_en) state_d = (pc_q == PC_LAST) ? ST_FINISH : ST_ISSUE;
  end

  // Control state, configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pc_q          <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      step_time_q   <= 17'd655;
      angle_noise_q <= 31'd16384;
      rate_proc_q   <= 31'd4;
      bias_proc_q   <= 31'd944;
      cross_proc_q  <= 31'd63;
      ang_q         <= '0;
      bias_q        <= '0;
      p11_q         <= '0;
      p12_q         <= '0;
      p22_q         <= '0;
      prev_q        <= '0;
      turn_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_TIME:   step_time_q   <= cfg_data_i[16:0];
          REG_ANGLE_NOISE: angle_noise_q <= cfg_data_i;
          REG_RATE_PROC:   rate_proc_q   <= cfg_data_i;
          REG_BIAS_PROC:   bias_proc_q   <= cfg_data_i;
          REG_CROSS_PROC:  cross_proc_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_UNWRAP) begin
        // A jump of more than pi counts one revolution.
        if (z_x < prev_x - PI_X) begin
          turn_q <= turn_q + 16'd1;
        end else if (z_x > prev_x + PI_X) begin
          turn_q <= turn_q - 16'd1;
        end
        prev_q <= z_q;
      end
      if (state_q == ST_ZADJ) pc_q <= '0;
      if (state_q == ST_ISSUE) cnt_q <= '0;
      if (state_q == ST_MUL || state_q == ST_DIV) cnt_q <= cnt_q + CW'(1);
      if (wb_en) begin
        pc_q <= pc_q + 5'd1;
        case (u.dst)
          SEL_P11:  p11_q  <= wb_val;
          SEL_P12:  p12_q  <= wb_val;
          SEL_P22:  p22_q  <= wb_val;
          SEL_ANG:  ang_q  <= wb_val;
          SEL_BIAS: bias_q <= wb_val;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and the shared unit's datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q    <= W'(angle_in_i);
      rate_q <= sat_x(XW'(rate_in_i));
    end
    if (state_q == ST_ZADJ) begin
      z_q <= sat_x(z_x + XW'($signed(turn_q)) * TWO_PI_X);
    end
    if (wb_en) begin
      case (u.dst)
        SEL_T:  t_q  <= wb_val;
        SEL_YS: ys_q <= wb_val;
        SEL_S:  s_q  <= wb_val;
        default: ;
      endcase
    end
    if (state_q == ST_ISSUE) begin
      neg_q <= opa[W-1] ^ opb[W-1];
      ma_q  <= mag(opa);
      mb_q  <= BW'(mag(opb));
      acc_q <= '0;
      dq_q  <= {mag(opa), {F{1'b0}}};
      ud_q  <= mag(opb);
      rem_q <= '0;
    end
    if (state_q == ST_MUL && cnt_q != MUL_END) begin
      acc_q <= acc_d;
      mb_q  <= mb_q << 4;
    end
    if (state_q == ST_DIV && cnt_q != DIV_END) begin
      rem_q <= ge ? W'(r2 - {1'b0, ud_q}) : W'(r2);
      dq_q  <= {dq_q[DW-2:0], ge};
    end
    if (out_load) begin
      ang_out_q  <= out32(ang_q);
      rate_out_q <= out32(sat_sum((W+1)'(rate_q) - (W+1)'(bias_q)));
      bias_out_q <= out32(bias_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = ang_out_q;
  assign corrected_rate_o = rate_out_q;
  assign bias_estimate_o  = bias_out_q;

endmodule
